@@ src/arq_rrw_pkg.sv @@
// types and constants of the arq receive reorder window
package arq_rrw_pkg;

  localparam int SEQ_W = 8;
  localparam int HND_W = 8;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_READ = 2'd1,
    MODE_SYNC = 2'd2,
    MODE_WIPE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_ALREADY   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_IN_SYNC   = 3'd4,
    ST_OUT_SYNC  = 3'd5,
    ST_DETACHED  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ADV,
    S_MAP,
    S_DONE
  } fsm_t;

  localparam logic [1:0] REG_RING_LENGTH = 2'd0;
  localparam logic [1:0] REG_HORIZON     = 2'd1;
  localparam logic [1:0] REG_INIT_SEQ    = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [SEQ_W-1:0] packet_sequence;
    logic [HND_W-1:0] payload_handle;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [5:0]       head_advance;
    logic [HND_W-1:0] read_handle;
    logic [SEQ_W-1:0] read_sequence;
    logic [15:0]      horizon_map;
    logic [4:0]       readable_count;
    logic [5:0]       stored_count;
  } out_word_t;

endpackage

@@ src/arq_receive_reorder_window.sv @@
// arq receive reorder window top level
// usage
//   in channel: a word (mode, packet_sequence, payload_handle) is taken at a
//   clock edge with in_start high and in_busy low. modes: push, read, sync
//   check, wipe.
//   out channel: one result word per input word, shown for one cycle with
//   out_strobe high; the receiver cannot stall, so nothing backs up.
//   cfg channel: apb-style write/read of the ring length (0x0), the horizon
//   limit (0x4) and the start sequence (0x8). writing the ring length while
//   idle wipes the ring.
// timing
//   slot data (handle, sequence) sit in a one-port synchronous memory; the
//   filled flags are flip-flops so the head walk and horizon map see them.
//   after the accepting edge the word passes the check state, then, for a
//   stored push or a read, the advance state (a read first pops the tail,
//   then the head walks one slot per cycle until the walk stops), then the
//   map and done states; out_strobe is high in done. busy drops in the
//   cycle after the strobe.
// reset
//   synchronous active-low reset empties the ring, clears the counts and
//   loads the register defaults (32 slots, horizon 16, sequence 0).
module arq_receive_reorder_window #(
  parameter int RING_DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_start,
  output logic                     in_busy,
  input  arq_rrw_pkg::in_word_t    in_word,
  output logic                     out_strobe,
  output arq_rrw_pkg::out_word_t   out_word,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import arq_rrw_pkg::*;

  localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);

  // config registers
  logic [5:0] ring_length_r;
  logic [4:0] horizon_r;
  logic [7:0] init_seq_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      REG_RING_LENGTH: prdata = {26'd0, ring_length_r};
      REG_HORIZON:     prdata = {27'd0, horizon_r};
      REG_INIT_SEQ:    prdata = {24'd0, init_seq_r};
      default:         prdata = 32'd0;
    endcase
  end

  // effective length and horizon
  logic [8:0] len_eff;
  logic [4:0] hor_eff;
  always_comb begin
    len_eff = {3'd0, ring_length_r};
    if (len_eff < 9'd3) len_eff = 9'd3;
    if (len_eff > 9'(RING_DEPTH)) len_eff = 9'(RING_DEPTH);
    hor_eff = horizon_r;
    if (hor_eff > 5'd16) hor_eff = 5'd16;
    if (9'(hor_eff) > len_eff - 9'd3) hor_eff = 5'(len_eff - 9'd3);
  end

  // slot data memory: {handle, sequence}
  logic [15:0] slot_mem [RING_DEPTH];
  logic        mem_we;
  logic [IW-1:0] mem_addr;
  logic [15:0] mem_wdata;
  logic [15:0] mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= slot_mem[mem_addr];
  end

  // state
  fsm_t          state_r, state_nxt;
  logic [RING_DEPTH-1:0] filled_r, filled_nxt;
  logic [IW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [7:0]    head_seq_r, head_seq_nxt;
  logic [CW-1:0] count_r, count_nxt;
  in_word_t      in_r, in_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [5:0]    adv_r, adv_nxt;
  logic [7:0]    rh_r, rh_nxt, rs_r, rs_nxt;
  logic [15:0]   map_r, map_nxt;
  logic [IW-1:0] land_r, land_nxt;

  // ring helper: (a + b) mod len for a < len, b < len
  function automatic logic [IW-1:0] wrap(input logic [8:0] a, input logic [8:0] b,
                                         input logic [8:0] l);
    logic [9:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, l}) s = s - {1'b0, l};
    return IW'(s);
  endfunction

  logic [7:0] off;
  logic [7:0] in_off;
  logic [IW-1:0] hnext, hprobe;
  logic [8:0] readable;
  assign off    = in_r.packet_sequence - head_seq_r;
  assign in_off = in_word.packet_sequence - head_seq_r;
  assign hnext  = wrap(9'(head_r), 9'd1, len_eff);
  assign hprobe = wrap(9'(head_r), 9'(hor_eff) + 9'd1, len_eff);
  always_comb begin
    readable = 9'(head_r) + len_eff - 9'(tail_r);
    if (readable >= len_eff) readable = readable - len_eff;
  end

  always_comb begin
    state_nxt    = state_r;
    filled_nxt   = filled_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    head_seq_nxt = head_seq_r;
    count_nxt    = count_r;
    in_nxt       = in_r;
    status_nxt   = status_r;
    adv_nxt      = adv_r;
    rh_nxt       = rh_r;
    rs_nxt       = rs_r;
    map_nxt      = map_r;
    land_nxt     = land_r;
    mem_we       = 1'b0;
    mem_addr     = tail_r;
    mem_wdata    = {in_r.payload_handle, in_r.packet_sequence};
    case (state_r)
      S_IDLE: begin
        if (cfg_wr && cfg_idx == REG_RING_LENGTH) begin
          filled_nxt   = '0;
          head_nxt     = '0;
          tail_nxt     = '0;
          count_nxt    = '0;
          head_seq_nxt = init_seq_r;
        end else if (in_start) begin
          in_nxt     = in_word;
          status_nxt = ST_OK;
          adv_nxt    = '0;
          rh_nxt     = '0;
          rs_nxt     = '0;
          land_nxt   = wrap(9'(head_r), 9'(in_off), len_eff);
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = S_MAP;
        case (mode_t'(in_r.mode))
          MODE_PUSH: begin
            mem_addr = land_r;
            if (off > 8'(hor_eff)) begin
              status_nxt = ST_INVALID;
            end else if (filled_r[land_r]) begin
              status_nxt = ST_ALREADY;
            end else begin
              mem_we             = 1'b1;
              filled_nxt[land_r] = 1'b1;
              count_nxt          = count_r + 1'b1;
              state_nxt          = S_ADV;
            end
          end
          MODE_READ: begin
            // memory output for the tail arrives next cycle
            if (readable == 9'd0) begin
              status_nxt = ST_EMPTY;
            end else begin
              state_nxt = S_ADV;
            end
          end
          MODE_SYNC: begin
            if (off == 8'd0) status_nxt = ST_IN_SYNC;
            else if (off <= 8'd16) status_nxt = ST_OUT_SYNC;
            else status_nxt = ST_DETACHED;
          end
          default: begin
            filled_nxt   = '0;
            head_nxt     = '0;
            tail_nxt     = '0;
            count_nxt    = '0;
            head_seq_nxt = init_seq_r;
          end
        endcase
      end
      S_ADV: begin
        if (in_r.mode == MODE_READ) begin
          // pop the tail entry once, then the mode turns to push so the
          // following cycles only walk the head
          rh_nxt           = mem_rdata_r[15:8];
          rs_nxt           = mem_rdata_r[7:0];
          if (filled_r[tail_r] && count_r != '0) count_nxt = count_r - 1'b1;
          filled_nxt[tail_r] = 1'b0;
          tail_nxt         = wrap(9'(tail_r), 9'd1, len_eff);
          in_nxt.mode      = MODE_PUSH;
          state_nxt        = S_ADV;
        end else if (filled_r[head_r] && hprobe != tail_r && 9'(adv_r) < len_eff) begin
          head_nxt     = hnext;
          head_seq_nxt = head_seq_r + 8'd1;
          adv_nxt      = adv_r + 6'd1;
        end else begin
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        // bits at or past the horizon are masked, so i + 1 stays below len
        for (int i = 0; i < 16; i++) begin
          map_nxt[i] = (i < int'(hor_eff)) &&
                       filled_r[wrap(9'(head_r), 9'(i + 1), len_eff)];
        end
        state_nxt = S_DONE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      filled_r      <= '0;
      head_r        <= '0;
      tail_r        <= '0;
      head_seq_r    <= '0;
      count_r       <= '0;
      ring_length_r <= 6'd32;
      horizon_r     <= 5'd16;
      init_seq_r    <= 8'd0;
    end else begin
      state_r    <= state_nxt;
      filled_r   <= filled_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      head_seq_r <= head_seq_nxt;
      count_r    <= count_nxt;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_RING_LENGTH: ring_length_r <= pwdata[5:0];
          REG_HORIZON:     horizon_r     <= pwdata[4:0];
          REG_INIT_SEQ:    init_seq_r    <= pwdata[7:0];
          default:         ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r     <= in_nxt;
    status_r <= status_nxt;
    adv_r    <= adv_nxt;
    rh_r     <= rh_nxt;
    rs_r     <= rs_nxt;
    map_r    <= map_nxt;
    land_r   <= land_nxt;
  end

  assign in_busy    = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_DONE);
  always_comb begin
    out_word.status         = status_r;
    out_word.head_advance   = adv_r;
    out_word.read_handle    = rh_r;
    out_word.read_sequence  = rs_r;
    out_word.horizon_map    = map_r;
    out_word.readable_count = 5'(readable);
    out_word.stored_count   = 6'(count_r);
  end

  // checks
  assert property (@(posedge clk) disable iff (!rst_n)
    in_start && !in_busy |=> in_busy) else $error("start not taken");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("double strobe");
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(RING_DEPTH)) else $error("count overflow");

endmodule

@@ bench/tb_top.sv @@
// testbench of the arq receive reorder window: directed and random words against a predictor
module tb_top;
  import arq_rrw_pkg::*;

  // predictor of the reorder ring, with its own copy of state and registers
  class reorder_scoreboard;
    bit [5:0]  ring_len_reg;
    bit [4:0]  horizon_reg;
    bit [7:0]  init_seq_reg;
    bit        filled [32];
    bit [7:0]  handle_mem [32];
    bit [7:0]  seq_mem [32];
    int        head_idx, tail_idx, filled_cnt;
    bit [7:0]  head_sq, tail_sq;
    out_word_t pending_words [$];
    int        errors;

    function void reset_regs();
      ring_len_reg = 32;
      horizon_reg = 16;
      init_seq_reg = 0;
      clear_ring();
    endfunction

    function void clear_ring();
      foreach (filled[i]) begin
        filled[i] = 0;
        handle_mem[i] = 0;
        seq_mem[i] = 0;
      end
      head_idx = 0;
      tail_idx = 0;
      filled_cnt = 0;
      head_sq = init_seq_reg;
      tail_sq = init_seq_reg;
    endfunction

    function int ring_len();
      int l;
      l = ring_len_reg;
      if (l < 3) l = 3;
      if (l > 32) l = 32;
      return l;
    endfunction

    function int horizon();
      int h;
      h = horizon_reg;
      if (h > 16) h = 16;
      if (h > ring_len() - 3) h = ring_len() - 3;
      return h;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == REG_RING_LENGTH) begin
        ring_len_reg = val[5:0];
        clear_ring();
      end else if (idx == REG_HORIZON) begin
        horizon_reg = val[4:0];
      end else if (idx == REG_INIT_SEQ) begin
        init_seq_reg = val[7:0];
      end
    endfunction

    // head walk over filled slots, stopping before the horizon meets the tail
    function int walk_head();
      int moved;
      moved = 0;
      while (moved < ring_len() && filled[head_idx]) begin
        if ((head_idx + horizon() + 1) % ring_len() == tail_idx) break;
        head_idx = (head_idx + 1) % ring_len();
        head_sq++;
        moved++;
      end
      return moved;
    endfunction

    function void note_word(in_word_t w);
      out_word_t r;
      int l, h, idx;
      bit [7:0] off;
      l = ring_len();
      h = horizon();
      r = '0;
      case (mode_t'(w.mode))
        MODE_PUSH: begin
          off = w.packet_sequence - head_sq;
          if (off > h) begin
            r.status = ST_INVALID;
          end else begin
            idx = (head_idx + off) % l;
            if (filled[idx]) begin
              r.status = ST_ALREADY;
            end else begin
              filled[idx] = 1;
              handle_mem[idx] = w.payload_handle;
              seq_mem[idx] = w.packet_sequence;
              if (filled_cnt < 32) filled_cnt++;
              r.head_advance = 6'(walk_head());
            end
          end
        end
        MODE_READ: begin
          if ((head_idx + l - tail_idx) % l == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.read_handle = handle_mem[tail_idx];
            r.read_sequence = seq_mem[tail_idx];
            if (filled[tail_idx] && filled_cnt > 0) filled_cnt--;
            filled[tail_idx] = 0;
            tail_idx = (tail_idx + 1) % l;
            tail_sq++;
            r.head_advance = 6'(walk_head());
          end
        end
        MODE_SYNC: begin
          off = w.packet_sequence - head_sq;
          if (off == 0) r.status = ST_IN_SYNC;
          else if (off <= 16) r.status = ST_OUT_SYNC;
          else r.status = ST_DETACHED;
        end
        default: clear_ring();
      endcase
      for (int i = 0; i < h; i++)
        if (filled[(head_idx + 1 + i) % l]) r.horizon_map[i] = 1;
      r.readable_count = 5'((head_idx + l - tail_idx) % l);
      r.stored_count = 6'(filled_cnt);
      pending_words.push_back(r);
    endfunction

    task check_word(out_word_t got);
      out_word_t exp_w;
      if (pending_words.size() == 0) begin
        report_bad("unexpected result word", 0, got);
        return;
      end
      exp_w = pending_words.pop_front();
      if (got.status !== exp_w.status) report_bad("status", exp_w.status, got.status);
      if (got.head_advance !== exp_w.head_advance)
        report_bad("head_advance", exp_w.head_advance, got.head_advance);
      if (got.read_handle !== exp_w.read_handle)
        report_bad("read_handle", exp_w.read_handle, got.read_handle);
      if (got.read_sequence !== exp_w.read_sequence)
        report_bad("read_sequence", exp_w.read_sequence, got.read_sequence);
      if (got.horizon_map !== exp_w.horizon_map)
        report_bad("horizon_map", exp_w.horizon_map, got.horizon_map);
      if (got.readable_count !== exp_w.readable_count)
        report_bad("readable_count", exp_w.readable_count, got.readable_count);
      if (got.stored_count !== exp_w.stored_count)
        report_bad("stored_count", exp_w.stored_count, got.stored_count);
    endtask

    task report_bad(string what, logic [63:0] exp_v, logic [63:0] got_v);
      errors++;
      $display("mismatch %s: expected %0h got %0h", what, exp_v, got_v);
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_start = 0;
  logic        in_busy;
  in_word_t    in_word = '0;
  logic        out_strobe;
  out_word_t   out_word;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  reorder_scoreboard board;
  int idle_pct;

  arq_receive_reorder_window dut (
    .clk(clk), .rst_n(rst_n),
    .in_start(in_start), .in_busy(in_busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // result words are checked at the edge that accepts them
  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_word(out_word);
  end

  // one word per handshake; the start stays high until the block takes it
  task automatic send_word(logic [1:0] m, logic [7:0] sq, logic [7:0] hd);
    in_word_t w;
    w = '{mode: m, packet_sequence: sq, payload_handle: hd};
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk);
    in_word <= w;
    in_start <= 1;
    @(posedge clk);
    while (in_busy) @(posedge clk);
    board.note_word(w);
    @(negedge clk);
    in_start <= 0;
    // the block is busy here anyway
    @(negedge clk);
  endtask

  // wait until every expected word is back, then let the block settle
  task automatic drain();
    int guard;
    guard = 0;
    while (board.pending_words.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (60) @(negedge clk);
  endtask

  // apb write: setup then access, only while the ring is idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.write_reg(idx, val);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // mostly in-window pushes and reads, some noise
  task automatic random_words(int n);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 55)
        send_word(MODE_PUSH, 8'(board.head_sq + $urandom_range(board.horizon() + 1)),
                  8'($urandom));
      else if (pick < 80) send_word(MODE_READ, 8'($urandom), 8'($urandom));
      else if (pick < 88) send_word(MODE_PUSH, 8'($urandom), 8'($urandom));
      else if (pick < 97)
        send_word(MODE_SYNC, 8'(board.head_sq + $urandom_range(20) - 2), 8'($urandom));
      else send_word(MODE_WIPE, 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    board = new();
    board.reset_regs();
    idle_pct = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: pushes out of order, duplicates, beyond horizon, reads, sync, wipe
    send_word(MODE_READ, 8'h00, 8'h00);           // read of empty ring
    send_word(MODE_PUSH, 8'd2, 8'hff);
    send_word(MODE_PUSH, 8'd1, 8'h00);
    send_word(MODE_PUSH, 8'd1, 8'h55);            // already in
    send_word(MODE_PUSH, 8'd17, 8'haa);           // beyond horizon
    send_word(MODE_PUSH, 8'd16, 8'h80);           // horizon edge
    send_word(MODE_PUSH, 8'd0, 8'h01);            // fills hole, head walks
    send_word(MODE_PUSH, 8'hff, 8'h7f);           // behind head
    send_word(MODE_SYNC, 8'd3, 8'h00);
    send_word(MODE_SYNC, 8'd19, 8'h00);
    send_word(MODE_SYNC, 8'd20, 8'h00);
    send_word(MODE_SYNC, 8'hff, 8'hff);
    for (int k = 0; k < 4; k++) send_word(MODE_READ, 8'h00, 8'h00);
    send_word(MODE_WIPE, 8'hff, 8'hff);
    // pushes at the head sequence, so the head walks one slot on each push
    for (int k = 0; k < 6; k++) send_word(MODE_PUSH, board.head_sq, 8'(k));

    // settings: extremes, small rings, wraparound initial sequence
    write_reg(REG_INIT_SEQ, 32'hfa);
    write_reg(REG_RING_LENGTH, 32'd3);             // horizon clamps to zero
    random_words(40);
    write_reg(REG_RING_LENGTH, 32'd0);
    write_reg(REG_HORIZON, 32'd31);
    idle_pct = 53;
    random_words(40);
    write_reg(REG_RING_LENGTH, 32'd63);
    write_reg(REG_HORIZON, 32'd0);
    write_reg(REG_INIT_SEQ, 32'hff);
    random_words(40);
    write_reg(REG_RING_LENGTH, 32'd8);
    write_reg(REG_HORIZON, 32'd4);
    write_reg(REG_INIT_SEQ, 32'h00);
    idle_pct = 6;
    random_words(80);
    write_reg(REG_RING_LENGTH, 32'd20);
    write_reg(REG_HORIZON, 32'd16);
    write_reg(REG_INIT_SEQ, 32'h81);
    idle_pct = 0;
    random_words(100);
    write_reg(REG_RING_LENGTH, 32'd32);
    write_reg(REG_HORIZON, 32'd10);
    idle_pct = 53;
    random_words(100);
    write_reg(REG_HORIZON, 32'd16);
    write_reg(REG_INIT_SEQ, 32'h7e);
    write_reg(REG_RING_LENGTH, 32'd17);
    idle_pct = 0;
    random_words(100);
    drain();

    if (board.errors == 0 && board.pending_words.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_top failed");
    $finish;
  end
endmodule

@@ arq_receive_reorder_window.f @@
src/arq_rrw_pkg.sv
src/arq_receive_reorder_window.sv
bench/tb_top.sv
